// ===== rtl/chcc_pkg.sv =====
// Package for the container header CRC checker.
// Holds the shared types, header and CRC constants, and the CRC and tag helper functions.
// No dependencies.
`default_nettype none

package chcc_pkg;

    // Reflected CRC-32 polynomial and the output mask
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_OUT_MASK = 32'h7FFF_FFFF;

    // Header is 16 bytes: raw length, container length, stored CRC, tag
    localparam int unsigned HDR_BYTES = 16;

    // Stream widths
    localparam int unsigned IN_TDATA_BITS  = 8;
    localparam int unsigned OUT_TDATA_BITS = 72;

    // Frame type code for an invalid frame or an unknown tag
    localparam logic [3:0] FT_INVALID = 4'd0;

    // Known tags, first character in the low byte; type code is index + 1
    localparam int unsigned NUM_TAGS = 8;
    localparam logic [31:0] TAG_CODES [NUM_TAGS] = '{
        "OZLM", "TPRC", "BILZ", "PIZB", "FZLL", "AMZL", "TSAF", "INIM"
    };

    // One byte handed from the input register to the frame logic
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } step_t;

    // One frame result
    typedef struct packed {
        logic [3:0]  frame_type;
        logic        crc_ok;
        logic [31:0] raw_length;
        logic [30:0] computed_crc;
    } result_t;

    // Fold one byte into a reflected CRC-32, no inversion
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] t;
        t = {24'h0, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++)
        begin
            t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
        end
        return (crc >> 8) ^ t;
    endfunction

    // Map a four-character tag to its type code
    function automatic logic [3:0] tag_type(input logic [31:0] tag);
        logic [3:0] code;
        code = FT_INVALID;
        for (int i = NUM_TAGS - 1; i >= 0; i--)
        begin
            if (TAG_CODES[i] == tag)
            begin
                code = 4'(i + 1);
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/chcc_frame_core.sv =====
// Frame state of the container header CRC checker: header capture, byte count, CRC.
// Produces the frame result combinationally for the byte being folded in.
// Depends on chcc_pkg.
`default_nettype none

module chcc_frame_core
    import chcc_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire step_t   step,
    output result_t      result
);

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [31:0]           crc_reg, crc_next;
    logic [31:0]           raw_len_reg, raw_len_next;
    logic [31:0]           cont_len_reg, cont_len_next;
    logic [31:0]           stored_crc_reg, stored_crc_next;
    logic [31:0]           tag_reg, tag_next;

    logic                  hdr_phase;
    logic [31:0]           shifted;
    logic                  frame_valid;
    logic [3:0]            ftype;
    logic [30:0]           crc_masked;

    // Header capture, CRC update and count for the current byte
    always_comb
    begin
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        crc_next        = crc_reg;
        raw_len_next    = raw_len_reg;
        cont_len_next   = cont_len_reg;
        stored_crc_next = stored_crc_reg;
        tag_next        = tag_reg;

        hdr_phase = (count_reg < COUNT_BITS'(HDR_BYTES));
        shifted   = 32'(step.data) << {count_reg[1:0], 3'b000};

        if (step.valid)
        begin
            if (hdr_phase)
            begin
                case (count_reg[3:2])
                    2'd0:    raw_len_next    = raw_len_reg | shifted;
                    2'd1:    cont_len_next   = cont_len_reg | shifted;
                    2'd2:    stored_crc_next = stored_crc_reg | shifted;
                    default: tag_next        = tag_reg | shifted;
                endcase
                // Seed the CRC once the header is complete
                if (count_reg[3:0] == 4'hF)
                begin
                    crc_next = raw_len_next ^ (cont_len_next - 32'(HDR_BYTES));
                end
            end
            else
            begin
                crc_next = crc_byte(crc_reg, step.data);
            end

            // Saturating byte count
            if (count_reg == '1)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Result for a final byte, from the updated state
    always_comb
    begin
        frame_valid = !ovf_next && (count_next > COUNT_BITS'(HDR_BYTES)) &&
                      (32'(count_next) == cont_len_next);
        ftype       = frame_valid ? tag_type(tag_next) : FT_INVALID;
        crc_masked  = crc_next[30:0];

        result.frame_type   = ftype;
        result.crc_ok       = (ftype != FT_INVALID) && ({1'b0, crc_masked} == stored_crc_next);
        result.raw_length   = raw_len_next;
        result.computed_crc = crc_masked;
    end

    // Frame state; cleared after each final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            crc_reg        <= '0;
            raw_len_reg    <= '0;
            cont_len_reg   <= '0;
            stored_crc_reg <= '0;
            tag_reg        <= '0;
        end
        else if (step.valid && step.last)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            crc_reg        <= '0;
            raw_len_reg    <= '0;
            cont_len_reg   <= '0;
            stored_crc_reg <= '0;
            tag_reg        <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            crc_reg        <= crc_next;
            raw_len_reg    <= raw_len_next;
            cont_len_reg   <= cont_len_next;
            stored_crc_reg <= stored_crc_next;
            tag_reg        <= tag_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/container_header_crc_checker.sv =====
// Top level of the container header CRC checker: input register, frame core, result register.
// Depends on chcc_pkg and chcc_frame_core.
//
// Channel   Dir  tdata fields (low bit up)                                 tlast
// s_axis    in   data_byte[7:0]                                            last_byte
// m_axis    out  frame_type[3:0], crc_ok[4], raw_length[36:5],
//                computed_crc[67:37], zero pad [71:68]                     -
//
// One byte per cycle sustained while no result waits on m_axis; the reflected CRC update
// of one byte per cycle sets that rate. A result's tvalid rises once its final byte has passed
// the input register and then the result register.
// Only the final byte of a frame yields a transaction on m_axis.
// While a result waits on m_axis, one more byte is held in the input register; s_axis stalls
// after that. Reset clears all frame state and both valid flags.
`default_nettype none

module container_header_crc_checker
    import chcc_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output      logic                      s_axis_tready,
    input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // data_byte[7:0]
    input  wire logic                      s_axis_tlast,   // last_byte
    output      logic                      m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output      logic [OUT_TDATA_BITS-1:0] m_axis_tdata    // frame_type, crc_ok, raw_length,
                                                           // computed_crc, pad
);

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    logic       out_valid_reg;
    result_t    out_result_reg;

    logic       advance;
    step_t      step;
    result_t    result;

    // Byte moves into the frame core when the result slot can take its outcome
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign step.valid = advance;
    assign step.data  = in_data_reg;
    assign step.last  = in_last_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    chcc_frame_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_result_reg.computed_crc, out_result_reg.raw_length,
                            out_result_reg.crc_ok, out_result_reg.frame_type};

endmodule

`default_nettype wire

// ===== rtl/chcc_checker.sv =====
// Port-level checks for the container header CRC checker, bound to the top level.
// Depends on chcc_pkg and container_header_crc_checker.
`default_nettype none

module chcc_checker
    import chcc_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_axis_tready,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

    // A pending result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before transaction");

    // A taking sink never stalls the input side
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    // CRC match is only reported for a valid, known frame
    a_crc_ok_type: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> (m_axis_tdata[3:0] != FT_INVALID))
        else $error("crc_ok set on invalid frame");

    // Type code within the tag list
    a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] <= 4'(NUM_TAGS)))
        else $error("frame_type out of range");

    // Pad bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[71:68] == 4'b0000))
        else $error("tdata pad bits not zero");

endmodule

bind container_header_crc_checker chcc_checker u_chcc_checker (.*);

`default_nettype wire

// ===== tb/container_header_crc_checker_tb.sv =====
`timescale 1ns / 1ps
// Testbench for container_header_crc_checker: streams framed containers in and checks each result.
// Depends on chcc_pkg and the RTL top level. A local table-driven CRC predictor produces the
// expected results.
module container_header_crc_checker_tb;
    import chcc_pkg::*;

    // Byte counter width of the block under test
    localparam int CNT_BITS    = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    // Known tags, bytes reversed so that the first character sits in the low byte
    localparam logic [31:0] TAG_WORDS [8] = '{
        "OZLM", "TPRC", "BILZ", "PIZB", "FZLL", "AMZL", "TSAF", "INIM"
    };

    typedef struct {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    typedef enum int {
        FR_GOOD, FR_BAD_CRC, FR_BAD_LEN, FR_BAD_TAG, FR_SHORT, FR_NOISE
    } frame_kind_e;

    typedef enum int { PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH } idle_phase_e;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
    logic                      s_axis_tlast = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    stream_byte_t pending_bytes [$];
    result_t      expected_results [$];
    stream_byte_t drv_item;
    result_t      mon_want;
    result_t      mon_got;
    idle_phase_e  idle_phase = PH_FREE;
    logic         hold_start = 1'b0;
    int           hold_cnt = 0;
    int           send_calm = 0;
    int           recv_calm = 0;
    int           errors = 0;

    // Predictor state for the frame in flight
    logic [CNT_BITS-1:0] fr_count;
    logic [31:0]         fr_crc;
    logic [31:0]         fr_raw;
    logic [31:0]         fr_len;
    logic [31:0]         fr_stored;
    logic [31:0]         fr_tag;
    logic                fr_ovf;
    logic [31:0]         crc_table [256];

    container_header_crc_checker #(
        .COUNT_BITS(CNT_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
        return (c >> 8) ^ crc_table[c[7:0] ^ b];
    endfunction

    function automatic logic [3:0] tag_kind(input logic [31:0] t);
        logic [3:0] k;
        k = FT_INVALID;
        for (int i = 0; i < 8; i++)
        begin
            if (k == FT_INVALID && TAG_WORDS[i] == t)
            begin
                k = 4'(i + 1);
            end
        end
        return k;
    endfunction

    function automatic int idle_pct(input bit recv_side);
        case (idle_phase)
            PH_SEND_IDLE:  return recv_side ? 0 : 51;
            PH_RECV_STALL: return recv_side ? 51 : 0;
            PH_BOTH:       return 31;
            default:       return 0;
        endcase
    endfunction

    task automatic clear_frame();
        fr_count  = '0;
        fr_crc    = '0;
        fr_raw    = '0;
        fr_len    = '0;
        fr_stored = '0;
        fr_tag    = '0;
        fr_ovf    = 1'b0;
    endtask

    // Fold one accepted byte into the frame state; the final byte yields one result
    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic [31:0] idx;
        logic [31:0] shifted;
        logic [31:0] masked;
        logic        valid;
        result_t     r;
        idx = 32'(fr_count);
        if (idx < HDR_BYTES)
        begin
            shifted = 32'(b) << (8 * idx[1:0]);
            case (idx[3:2])
                2'd0:    fr_raw    = fr_raw | shifted;
                2'd1:    fr_len    = fr_len | shifted;
                2'd2:    fr_stored = fr_stored | shifted;
                default: fr_tag    = fr_tag | shifted;
            endcase
            if (idx == HDR_BYTES - 1)
            begin
                fr_crc = fr_raw ^ (fr_len - HDR_BYTES);
            end
        end
        else
        begin
            fr_crc = crc_fold(fr_crc, b);
        end
        // saturating count
        if (&fr_count)
        begin
            fr_ovf = 1'b1;
        end
        else
        begin
            fr_count = fr_count + 1'b1;
        end
        if (last)
        begin
            valid = !fr_ovf && (32'(fr_count) > HDR_BYTES) && (32'(fr_count) == fr_len);
            masked = fr_crc & CRC_OUT_MASK;
            r.frame_type   = valid ? tag_kind(fr_tag) : FT_INVALID;
            r.crc_ok       = (r.frame_type != FT_INVALID) && (masked == fr_stored);
            r.raw_length   = fr_raw;
            r.computed_crc = masked[30:0];
            expected_results.push_back(r);
            clear_frame();
        end
    endtask

    // Build one container and queue its bytes; keep != 0 cuts a longer frame to that many bytes
    task automatic queue_frame(input frame_kind_e kind, input int plen, input int keep,
                               input logic [31:0] raw, input int tag_sel, output int nbytes);
        logic [7:0]  body [$];
        logic [7:0]  frame [$];
        logic [31:0] clen;
        logic [31:0] stored;
        logic [31:0] tag;
        logic [31:0] acc;
        stream_byte_t sb;
        for (int i = 0; i < plen; i++)
        begin
            body.push_back(8'($urandom()));
        end
        tag  = TAG_WORDS[tag_sel];
        clen = 32'(plen) + HDR_BYTES;
        case (kind)
            FR_BAD_LEN:
            begin
                if ($urandom_range(0, 1) != 0)
                    clen = clen + 32'($urandom_range(1, 3));
                else
                    clen = clen - 32'($urandom_range(1, 3));
            end
            FR_BAD_TAG: tag = tag ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
            default: ;
        endcase
        // stored CRC as the block would compute it from this header
        acc = raw ^ (clen - HDR_BYTES);
        foreach (body[i])
        begin
            acc = crc_fold(acc, body[i]);
        end
        stored = acc & CRC_OUT_MASK;
        if (kind == FR_BAD_CRC)
        begin
            stored = stored ^ (32'd1 << $urandom_range(0, 31));
        end
        if (kind == FR_NOISE)
        begin
            clen   = ($urandom_range(0, 3) == 0) ? clen : $urandom();
            stored = $urandom();
            tag    = $urandom();
        end
        for (int i = 0; i < 4; i++) frame.push_back(raw[8*i +: 8]);
        for (int i = 0; i < 4; i++) frame.push_back(clen[8*i +: 8]);
        for (int i = 0; i < 4; i++) frame.push_back(stored[8*i +: 8]);
        for (int i = 0; i < 4; i++) frame.push_back(tag[8*i +: 8]);
        foreach (body[i])
        begin
            frame.push_back(body[i]);
        end
        nbytes = (keep != 0 && keep < frame.size()) ? keep : frame.size();
        for (int i = 0; i < nbytes; i++)
        begin
            sb.data = frame[i];
            sb.last = (i == nbytes - 1);
            pending_bytes.push_back(sb);
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Sender: offers the next pending byte, predicts on each accepted transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_calm     <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_byte(s_axis_tdata, s_axis_tlast);
            end
            if (send_calm != 0)
                send_calm <= send_calm - 1;
            else if ($urandom_range(0, 63) == 0)
                send_calm <= $urandom_range(8, 40);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_bytes.size() != 0 &&
                    !(send_calm == 0 && $urandom_range(0, 99) < idle_pct(1'b0)))
                begin
                    drv_item = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= drv_item.data;
                    s_axis_tlast  <= drv_item.last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_start)
            hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    // Receiver: checks each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_calm     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                mon_got.frame_type   = m_axis_tdata[3:0];
                mon_got.crc_ok       = m_axis_tdata[4];
                mon_got.raw_length   = m_axis_tdata[36:5];
                mon_got.computed_crc = m_axis_tdata[67:37];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: type %0d ok %0d raw %h crc %h", $time,
                             mon_got.frame_type, mon_got.crc_ok, mon_got.raw_length,
                             mon_got.computed_crc);
                    errors++;
                end
                else
                begin
                    mon_want = expected_results.pop_front();
                    if (mon_got !== mon_want)
                    begin
                        $display("%0t: mismatch: expected type %0d ok %0d raw %h crc %h",
                                 $time, mon_want.frame_type, mon_want.crc_ok,
                                 mon_want.raw_length, mon_want.computed_crc);
                        $display("%0t:           actual type %0d ok %0d raw %h crc %h",
                                 $time, mon_got.frame_type, mon_got.crc_ok,
                                 mon_got.raw_length, mon_got.computed_crc);
                        errors++;
                    end
                end
            end
            if (recv_calm != 0)
                recv_calm <= recv_calm - 1;
            else if ($urandom_range(0, 63) == 0)
                recv_calm <= $urandom_range(8, 40);
            m_axis_tready <= (hold_cnt == 0) &&
                             !(recv_calm == 0 && $urandom_range(0, 99) < idle_pct(1'b1));
        end
    end

    // Stimulus: directed frames, then random frames per idle phase
    initial
    begin
        logic [31:0] v;
        int          n;
        int          ph_bytes;
        int          ph_frames;
        int          pick;
        int          plen;
        int          keep;
        frame_kind_e kind;
        for (int i = 0; i < 256; i++)
        begin
            v = 32'(i);
            for (int k = 0; k < 8; k++)
            begin
                v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
            end
            crc_table[i] = v;
        end
        clear_frame();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 4; p++)
        begin
            @(negedge clk);
            idle_phase = idle_phase_e'(p);
            if (p == PH_FREE)
            begin
                // single-byte frames, all zeros and all ones
                queue_frame(FR_SHORT, 0, 1, 32'h0000_0000, 0, n);
                queue_frame(FR_SHORT, 0, 1, 32'hFFFF_FFFF, 0, n);
                // header only: length matches but the frame is too short
                queue_frame(FR_GOOD, 0, 0, $urandom(), 1, n);
                // partial header
                queue_frame(FR_SHORT, 0, 9, $urandom(), 2, n);
                // minimum-length frames, two with extreme raw lengths; good, bad CRC, bad tag
                queue_frame(FR_GOOD, 1, 0, 32'hFFFF_FFFF, 0, n);
                queue_frame(FR_BAD_CRC, 1, 0, 32'h0000_0000, 7, n);
                queue_frame(FR_BAD_TAG, 1, 0, $urandom(), 3, n);
            end
            ph_bytes  = 0;
            ph_frames = 0;
            while (ph_bytes < 210 || ph_frames < 6)
            begin
                pick = $urandom_range(0, 99);
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                   : $urandom_range(1, 24);
                if (pick < 65)      kind = FR_GOOD;
                else if (pick < 72) kind = FR_BAD_CRC;
                else if (pick < 79) kind = FR_BAD_LEN;
                else if (pick < 86) kind = FR_BAD_TAG;
                else if (pick < 93) kind = FR_SHORT;
                else                kind = FR_NOISE;
                keep = (kind == FR_SHORT) ? $urandom_range(1, 16) : 0;
                queue_frame(kind, plen, keep, $urandom(), ph_frames % 8, n);
                ph_bytes += n;
                ph_frames++;
            end
            if (p == PH_RECV_STALL)
            begin
                hold_start = 1'b1;
                @(negedge clk);
                hold_start = 1'b0;
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #16_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/chcc_pkg.sv
rtl/chcc_frame_core.sv
rtl/container_header_crc_checker.sv
rtl/chcc_checker.sv
tb/container_header_crc_checker_tb.sv
